// File: rtl/texp_pkg.sv
// ----------------------------------------------------------------------------
// texp_pkg: shared types and constants for the exponential series core
// Number formats, datapath widths and the payload structures that travel
// through the term pipeline and into the output buffer.
// ----------------------------------------------------------------------------
package texp_pkg;

  // Argument x is Q3.12, every term and the running sum are Q15.16.
  localparam int X_W        = 16;
  localparam int TERM_W     = 32;
  localparam int PROD_W     = 48;
  localparam int FRAC_SHIFT = 12;

  // Term count register.
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] TERM_COUNT_RST = 6'd10;

  // Configuration port.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_TERM_COUNT = 1'b0;

  // Scaled quotient and its split for the two-digit constant division.
  // The scaled quotient is below 2^35, the divisor is below 64.
  localparam int QUOT_W = 35;
  localparam int LO_W   = 17;
  localparam int HI_W   = QUOT_W - LO_W;
  localparam int REM_W  = 6;
  localparam int V_W    = REM_W + LO_W;
  localparam int LIM_W  = 38;

  localparam logic signed [TERM_W-1:0] ONE_Q16  = 32'sh0001_0000;
  localparam logic signed [TERM_W-1:0] TERM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TERM_W-1:0] TERM_MIN = 32'sh8000_0000;

  // Per-item fields that ride along the term pipeline.
  typedef struct packed {
    logic signed [TERM_W-1:0] sum;
    logic signed [X_W-1:0]    x;
    logic [CNT_W-1:0]         n;
    logic                     sat;
  } side_t;

  // One finished result.
  typedef struct packed {
    logic signed [TERM_W-1:0] sum;
    logic                     sat;
  } result_t;

endpackage

// File: rtl/taylor_exp_series_core.sv
// ----------------------------------------------------------------------------
// taylor_exp_series_core: e^x by a truncated Taylor series, Q3.12 in, Q15.16 out
// Pipeline: eight register stages per term stage, then the output buffer.
// Throughput: one transaction per cycle; the pipeline stalls only while the
//   two-entry output buffer is full.
// Reset: synchronous; clears all valid bits and the buffer, term_count = 10.
// ----------------------------------------------------------------------------
module taylor_exp_series_core #(
  parameter int MAX_TERMS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [texp_pkg::ADDR_W-1:0]         paddr,
  input  logic [texp_pkg::DATA_W-1:0]         pwdata,
  output logic [texp_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [texp_pkg::X_W-1:0]     x_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [texp_pkg::TERM_W-1:0]  exp_approx,
  output logic                                saturated
);
  import texp_pkg::*;

  localparam int NSTG = MAX_TERMS - 1;
  localparam logic [CNT_W:0] MAX_N = (CNT_W + 1)'(MAX_TERMS);

  logic [CNT_W-1:0] term_count;
  logic [CNT_W-1:0] n_eff;
  logic             en;
  logic             ob_full;
  result_t          ob_in, ob_out;

  side_t                    chain_side  [MAX_TERMS];
  logic signed [TERM_W-1:0] chain_term  [MAX_TERMS];
  logic [NSTG:0]            chain_valid;

  // Configuration register write and read-back.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RST;
    end else if (psel && penable && pwrite && pready
                 && paddr[ADDR_W-1] == REG_TERM_COUNT) begin
      term_count <= pwdata[CNT_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_TERM_COUNT)
                ? DATA_W'(term_count) : '0;

  // Effective term count: zero means one term, capped at MAX_TERMS.
  always_comb begin
    if (term_count == '0) begin
      n_eff = CNT_W'(1);
    end else if ({1'b0, term_count} > MAX_N) begin
      n_eff = CNT_W'(MAX_N);
    end else begin
      n_eff = term_count;
    end
  end

  // The whole pipeline advances unless the output buffer is full.
  assign en       = ~ob_full;
  assign in_ready = en;

  // Pipeline entry: constant term one and sum one.
  assign chain_valid[0]    = in_valid;
  assign chain_side[0].sum = ONE_Q16;
  assign chain_side[0].x   = x_value;
  assign chain_side[0].n   = n_eff;
  assign chain_side[0].sat = 1'b0;
  assign chain_term[0]     = ONE_Q16;

  // One stage per series term after the constant.
  for (genvar g = 1; g <= NSTG; g++) begin : g_term
    texp_term #(
      .STAGE_IDX (g)
    ) u_term (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[g-1]),
      .in_side   (chain_side[g-1]),
      .in_term   (chain_term[g-1]),
      .out_valid (chain_valid[g]),
      .out_side  (chain_side[g]),
      .out_term  (chain_term[g])
    );
  end

  // Output buffer.
  assign ob_in.sum = chain_side[NSTG].sum;
  assign ob_in.sat = chain_side[NSTG].sat;

  texp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (chain_valid[NSTG] & en),
    .push_data (ob_in),
    .full      (ob_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (ob_out)
  );

  assign exp_approx = ob_out.sum;
  assign saturated  = ob_out.sat;

  // For a Q3.12 argument no term or partial sum can reach the Q15.16 limits.
  a_no_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !saturated)
    else $error("series result clipped for an in-range argument");

  // A stalled pipeline holds its last stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> ($stable(chain_valid[NSTG]) && $stable(chain_side[NSTG])))
    else $error("pipeline tail changed during a stall");

endmodule

// File: rtl/texp_term.sv
// ----------------------------------------------------------------------------
// texp_term: one series term stage
// Forms term * x / (i * 4096) with round-half-away rounding and saturation,
// then adds the new term to the running sum when the stage index is below
// the term count. Eight register stages; one item per cycle while en is high.
// ----------------------------------------------------------------------------
module texp_term #(
  parameter int STAGE_IDX = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  texp_pkg::side_t                  in_side,
  input  logic signed [texp_pkg::TERM_W-1:0] in_term,
  output logic                             out_valid,
  output texp_pkg::side_t                  out_side,
  output logic signed [texp_pkg::TERM_W-1:0] out_term
);
  import texp_pkg::*;

  localparam int SUB = 8;

  // Rounding bias i * 2048 and the reciprocal constants of 1 / i.
  localparam logic [PROD_W-1:0] BIAS     = PROD_W'(STAGE_IDX) << (FRAC_SHIFT - 1);
  localparam logic [HI_W:0]     RECIP_HI = (HI_W + 1)'((1 << HI_W) / STAGE_IDX);
  localparam logic [V_W:0]      RECIP_LO = (V_W + 1)'((1 << V_W) / STAGE_IDX);
  localparam logic [HI_W-1:0]   IDX_HI   = HI_W'(STAGE_IDX);
  localparam logic [V_W-1:0]    IDX_V    = V_W'(STAGE_IDX);
  localparam logic [REM_W-1:0]  IDX_REM  = REM_W'(STAGE_IDX);
  localparam logic [CNT_W-1:0]  IDX_CNT  = CNT_W'(STAGE_IDX);
  // Quotient limits beyond which the term clips.
  localparam logic [LIM_W-1:0]  LIM_POS  = LIM_W'(STAGE_IDX) << (TERM_W - 1);
  localparam logic [LIM_W-1:0]  LIM_NEG  = LIM_POS + LIM_W'(STAGE_IDX);

  logic [SUB-1:0] vld;
  side_t          side_q [SUB];

  logic signed [PROD_W-1:0] prod_a;
  logic                     neg_b;
  logic [QUOT_W-1:0]        t_b;
  logic                     neg_c, clip_c;
  logic [HI_W-1:0]          hi_c, qh0_c;
  logic [LO_W-1:0]          lo_c;
  logic                     neg_d, clip_d;
  logic [HI_W-1:0]          qh_d;
  logic [REM_W-1:0]         rh_d;
  logic [LO_W-1:0]          lo_d;
  logic                     neg_e, clip_e;
  logic [HI_W-1:0]          qh_e;
  logic [V_W-1:0]           v_e;
  logic [LO_W-1:0]          ql0_e;
  logic                     neg_f, clip_f;
  logic [TERM_W-1:0]        q_f;
  logic                     clip_g;
  logic signed [TERM_W-1:0] term_g;
  logic signed [TERM_W-1:0] term_h;

  logic [PROD_W-1:0]   pos_sum_b, neg_sum_b, biased_b;
  logic [QUOT_W-1:0]   t_next;
  logic [HI_W-1:0]     hi_next;
  logic [2*HI_W:0]     mul_hi;
  logic [LIM_W-1:0]    t_ext;
  logic                clip_next;
  logic [HI_W-1:0]     back_d, rh0_d;
  logic                corr_d;
  logic [V_W-1:0]      v_next;
  logic [2*V_W:0]      mul_lo;
  logic [V_W-1:0]      ql0_ext, back_f, rl0_f;
  logic [LO_W-1:0]     ql_f;
  logic [QUOT_W-1:0]   q_full;
  logic signed [TERM_W-1:0] term_next;
  logic signed [TERM_W:0]   sum_ext;
  logic                sum_ovf, active;
  logic signed [TERM_W-1:0] sum_sat;
  side_t               side_h;

  // Magnitude plus rounding bias, scaled down by 4096.
  assign pos_sum_b = $unsigned(prod_a) + BIAS;
  assign neg_sum_b = BIAS - $unsigned(prod_a);
  assign biased_b  = prod_a[PROD_W-1] ? neg_sum_b : pos_sum_b;
  assign t_next    = biased_b[FRAC_SHIFT +: QUOT_W];

  // High digit estimate by reciprocal, and the clip decision.
  assign hi_next   = t_b[LO_W +: HI_W];
  assign mul_hi    = hi_next * RECIP_HI;
  assign t_ext     = LIM_W'(t_b);
  assign clip_next = neg_b ? (t_ext >= LIM_NEG) : (t_ext >= LIM_POS);

  // High digit correction; the estimate is at most one short.
  assign back_d = qh0_c * IDX_HI;
  assign rh0_d  = hi_c - back_d;
  assign corr_d = (rh0_d >= IDX_HI);

  // Low digit estimate over remainder and low bits.
  assign v_next = {rh_d, lo_d};
  assign mul_lo = v_next * RECIP_LO;

  // Low digit correction and quotient assembly.
  assign ql0_ext = V_W'(ql0_e);
  assign back_f  = ql0_ext * IDX_V;
  assign rl0_f   = v_e - back_f;
  assign ql_f    = (rl0_f >= IDX_V) ? ql0_e + 1'b1 : ql0_e;
  assign q_full  = {qh_e, ql_f};

  // Signed, saturated term.
  always_comb begin
    if (clip_f) begin
      term_next = neg_f ? TERM_MIN : TERM_MAX;
    end else if (neg_f) begin
      term_next = $signed(TERM_W'(0) - q_f);
    end else begin
      term_next = $signed(q_f);
    end
  end

  // Running sum update, only for stages inside the term count.
  assign sum_ext = {side_q[SUB-2].sum[TERM_W-1], side_q[SUB-2].sum}
                 + {term_g[TERM_W-1], term_g};
  assign sum_ovf = sum_ext[TERM_W] ^ sum_ext[TERM_W-1];
  assign sum_sat = sum_ovf ? (sum_ext[TERM_W] ? TERM_MIN : TERM_MAX)
                           : sum_ext[TERM_W-1:0];
  assign active  = (IDX_CNT < side_q[SUB-2].n);

  always_comb begin
    side_h = side_q[SUB-2];
    if (active) begin
      side_h.sum = sum_sat;
      side_h.sat = side_q[SUB-2].sat | clip_g | sum_ovf;
    end
  end

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SUB-2:0], in_valid};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= in_side;
      for (int k = 1; k < SUB - 1; k++) begin
        side_q[k] <= side_q[k-1];
      end
      side_q[SUB-1] <= side_h;

      prod_a <= $signed(in_term) * $signed(in_side.x);

      neg_b <= prod_a[PROD_W-1];
      t_b   <= t_next;

      neg_c  <= neg_b;
      clip_c <= clip_next;
      hi_c   <= hi_next;
      qh0_c  <= mul_hi[HI_W +: HI_W];
      lo_c   <= t_b[LO_W-1:0];

      neg_d  <= neg_c;
      clip_d <= clip_c;
      qh_d   <= corr_d ? qh0_c + 1'b1 : qh0_c;
      rh_d   <= corr_d ? REM_W'(rh0_d - IDX_HI) : REM_W'(rh0_d);
      lo_d   <= lo_c;

      neg_e  <= neg_d;
      clip_e <= clip_d;
      qh_e   <= qh_d;
      v_e    <= v_next;
      ql0_e  <= mul_lo[V_W +: LO_W];

      neg_f  <= neg_e;
      clip_f <= clip_e;
      q_f    <= q_full[TERM_W-1:0];

      clip_g <= clip_f;
      term_g <= term_next;

      term_h <= term_g;
    end
  end

  assign out_valid = vld[SUB-1];
  assign out_side  = side_q[SUB-1];
  assign out_term  = term_h;

  // After one correction the high remainder must be below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (rh_d < IDX_REM))
    else $error("high digit remainder not below divisor");

endmodule

// File: rtl/texp_obuf.sv
// ----------------------------------------------------------------------------
// texp_obuf: two-entry output buffer
// Decouples the pipeline stall from the output ready: the pipeline only
// stops when both entries hold results that have not been taken.
// ----------------------------------------------------------------------------
module texp_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  texp_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output texp_pkg::result_t out_data
);
  import texp_pkg::*;

  result_t    ent [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = ent[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  // A result written into an empty buffer shows up at the head next cycle.
  a_empty_push: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd0) |=> (out_valid && out_data == $past(push_data)))
    else $error("pushed result not at buffer head");

endmodule

// File: verif/taylor_exp_series_core_tb.sv
// ----------------------------------------------------------------------------
// taylor_exp_series_core_tb: self-checking bench for the exp series core
// Streams Q3.12 arguments through the core under several term counts and
// compares every Q15.16 sum and clip flag against a bit-exact local model
// of the truncated Taylor series, with random idling on both sides and one
// long output stall that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module taylor_exp_series_core_tb;
  import texp_pkg::*;

  localparam int SERIES_MAX  = 32;
  localparam int LATENCY     = 8 * (SERIES_MAX - 1);
  localparam int HOLD_CYCLES = 700;
  localparam int STALL_LIMIT = 4000;
  localparam logic [ADDR_W-1:0] TERM_COUNT_ADDR = ADDR_W'(4 * REG_TERM_COUNT);

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [X_W-1:0]    x_value;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TERM_W-1:0] exp_approx;
  logic                     saturated;

  // Bench state: the term count the core holds, pending sums and knobs.
  logic [CNT_W-1:0] term_count_shadow = TERM_COUNT_RST;
  result_t          expected_sums[$];
  int               mismatch_count = 0;
  int               send_idle_pct  = 21;
  int               recv_idle_pct  = 74;
  int               hold_left      = 0;
  int               quiet_cycles   = 0;

  taylor_exp_series_core #(
    .MAX_TERMS(SERIES_MAX)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_value   (x_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .exp_approx(exp_approx),
    .saturated (saturated)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp a value to the signed Q15.16 range.
  function automatic longint clamp_q16(input longint v);
    if (v > longint'(TERM_MAX)) return longint'(TERM_MAX);
    if (v < longint'(TERM_MIN)) return longint'(TERM_MIN);
    return v;
  endfunction

  // Sum the first terms of the series for one argument, bit for bit.
  function automatic result_t exp_series_predict(input logic signed [X_W-1:0] arg,
                                                 input logic [CNT_W-1:0] cnt);
    result_t r;
    longint  term;
    longint  total;
    longint  prod;
    longint  mag;
    longint  quot;
    longint  dvs;
    int      n;
    bit      clip;
    n = (cnt == 0) ? 1 : ((cnt > SERIES_MAX) ? SERIES_MAX : int'(cnt));
    term  = longint'(ONE_Q16);
    total = longint'(ONE_Q16);
    clip  = 1'b0;
    for (int i = 1; i < n; i++) begin
      // Next term is term * x / (i * 4096), rounded half away from zero.
      prod = term * longint'(arg);
      dvs  = longint'(i) << FRAC_SHIFT;
      mag  = (prod < 0) ? -prod : prod;
      quot = (mag + dvs / 2) / dvs;
      quot = (prod < 0) ? -quot : quot;
      term = clamp_q16(quot);
      clip |= (term != quot);
      quot  = total + term;
      total = clamp_q16(quot);
      clip |= (total != quot);
    end
    r.sum = total[TERM_W-1:0];
    r.sat = clip;
    return r;
  endfunction

  // Arguments biased toward zero, the field limits and whole numbers.
  function automatic logic signed [X_W-1:0] random_arg();
    int v;
    case ($urandom_range(0, 9))
      0:       v = int'($urandom_range(0, 256)) - 128;
      1:       v = 32703 + int'($urandom_range(0, 64));
      2:       v = -32768 + int'($urandom_range(0, 64));
      3:       v = (int'($urandom_range(0, 15)) - 8) * 4096;
      default: v = int'($urandom_range(0, 65535));
    endcase
    return v[X_W-1:0];
  endfunction

  // Term counts with the extremes of the register drawn often.
  function automatic logic [CNT_W-1:0] random_terms();
    case ($urandom_range(0, 5))
      0:       return CNT_W'(1);
      1:       return CNT_W'(SERIES_MAX);
      2:       return '0;
      3:       return '1;
      default: return CNT_W'($urandom_range(2, 31));
    endcase
  endfunction

  // Offer one argument and record its expected sum once the transaction is taken.
  task automatic send_arg(input logic signed [X_W-1:0] arg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    x_value  <= arg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_sums.push_back(exp_series_predict(arg, term_count_shadow));
  endtask

  // Let the core drain, then write the term count over the register port.
  task automatic set_term_count(input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] junk;
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    junk = $urandom;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TERM_COUNT_ADDR;
    // Only the low bits hold the count; the upper bits carry noise.
    pwdata  <= {junk[DATA_W-1:CNT_W], cnt};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    term_count_shadow = cnt;
  endtask

  // Field limits, whole units and every class of term count.
  task automatic test_directed_args();
    // Term count as left by reset.
    send_arg(16'sd0);     send_arg(16'sd4096);  send_arg(-16'sd4096);
    send_arg(16'sd32767); send_arg(-16'sd32768); send_arg(16'sd1); send_arg(-16'sd1);
    // A zero count still yields the constant term.
    set_term_count(CNT_W'(0));
    send_arg(16'sd4096);  send_arg(-16'sd32768);
    set_term_count(CNT_W'(1));
    send_arg(16'sd32767); send_arg(-16'sd5);
    set_term_count(CNT_W'(SERIES_MAX));
    send_arg(16'sd32767); send_arg(-16'sd32768); send_arg(16'sd12345); send_arg(-16'sd4096);
    // Counts above the pipeline depth behave as the full depth.
    set_term_count('1);
    send_arg(16'sd32767); send_arg(-16'sd32768);
    set_term_count(CNT_W'(SERIES_MAX + 1));
    send_arg(16'sd20000);
    // Two terms sum the constant and the first term, whose quotient is exact.
    set_term_count(CNT_W'(2));
    send_arg(16'sd1);     send_arg(-16'sd1);    send_arg(16'sd2048);
  endtask

  // Random arguments in bursts, each burst under a fresh term count.
  task automatic test_random_args(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      set_term_count(random_terms());
      repeat (50) send_arg(random_arg());
    end
  endtask

  // Hold the output off long enough for the pipeline to fill and stall input.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_term_count(CNT_W'(SERIES_MAX));
    hold_left = HOLD_CYCLES;
    repeat (400) send_arg(random_arg());
  endtask

  // Output side: random ready, or a counted hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Compare each result transaction with the oldest pending sum.
  always @(posedge clk) begin : check_results
    result_t want;
    if (out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("exp_approx: expected no result, got %0d", exp_approx);
        mismatch_count++;
      end else begin
        want = expected_sums.pop_front();
        if (exp_approx !== want.sum) begin
          $error("exp_approx: expected %0d, got %0d", want.sum, exp_approx);
          mismatch_count++;
        end
        if (saturated !== want.sat) begin
          $error("saturated: expected %0d, got %0d", want.sat, saturated);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    x_value  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed_args();
    test_random_args(21, 74);
    test_random_args(74, 21);
    test_random_args(0, 0);
    test_output_backpressure();

    // Drain, then watch a while longer for stray results.
    in_valid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
    if (mismatch_count == 0 && expected_sums.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
